>>> hw/rtl/qld_pkg.sv
`timescale 1ns / 1ps
// qld_pkg: shared types, constants and helpers for the q15 loss derivative pipeline
// no dependencies; imported by every qld module and by the top level

package qld_pkg;

    // field widths
    localparam int DATA_W     = 16;
    localparam int FRAC_BITS  = 15;
    localparam int MAG_W      = 15;                 // clamped output, divisor, quotient
    localparam int DIVIDEND_W = 31;                 // dividend magnitude
    localparam int PROD_W     = 30;                 // o * (32768 - o) fits here
    localparam int DIFF_W     = 18;                 // o - target, signed

    // divider layout: quotient bits resolved per stage and number of stages
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = MAG_W / DIV_STEPS;

    // clamp bounds of the model output
    localparam logic [MAG_W-1:0] O_MIN = 15'd1;
    localparam logic [MAG_W-1:0] O_MAX = 15'd32766;

    // saturation bounds of the result
    localparam logic signed [DATA_W-1:0] DER_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] DER_MIN = 16'sh8000;

    // loss selector codes
    typedef enum logic [1:0] {
        OP_MSE  = 2'd0,
        OP_BCE  = 2'd1,
        OP_CE   = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // item carried through the divider stages
    typedef struct packed {
        logic                     use_div;   // result comes from the quotient
        logic                     neg;       // quotient gets negated
        logic                     ovf;       // quotient magnitude >= 2^15
        logic signed [DATA_W-1:0] bypass;    // result when no division is used
        logic [MAG_W-1:0]         divisor;
        logic [MAG_W-1:0]         rem;       // partial remainder
        logic [MAG_W-1:0]         low;       // dividend bits not yet shifted in
        logic [MAG_W-1:0]         quo;       // quotient bits so far
    } div_item_t;

    // saturate an 18-bit signed value to q15
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [DIFF_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 18'sd32767)
        begin
            r = DER_MAX;
        end
        else if (v < -18'sd32768)
        begin
            r = DER_MIN;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/qld_prep.sv
`timescale 1ns / 1ps
// qld_prep: first two pipeline stages: clamp, denominator product, operand setup
// depends on qld_pkg

module qld_prep
    import qld_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               operation,
    input  logic signed [DATA_W-1:0] target,
    input  logic signed [DATA_W-1:0] prediction,
    output logic                     out_valid,
    input  logic                     out_ready,
    output div_item_t                out_item
);

    // stage a registers
    logic                     a_valid_reg;
    op_t                      a_op_reg;
    logic signed [DATA_W-1:0] a_tgt_reg;
    logic [MAG_W-1:0]         a_o_reg;
    logic [PROD_W-1:0]        a_prod_reg;
    logic signed [DIFF_W-1:0] a_diff_reg;

    // stage b registers
    logic                     b_valid_reg;
    div_item_t                b_item_reg;
    div_item_t                b_item_next;

    logic                     a_ready;
    logic                     b_ready;
    logic [MAG_W-1:0]         o_clamp;
    logic [DATA_W-1:0]        o_comp;
    logic [PROD_W-1:0]        prod_full;
    logic signed [DIFF_W-1:0] diff;

    logic [MAG_W-1:0]         den;
    logic [MAG_W-1:0]         den_f;
    logic signed [32:0]       bce_num;
    logic [32:0]              bce_mag;
    logic [DATA_W-1:0]        tgt_mag;
    logic [DIVIDEND_W-1:0]    dvd;

    // stage handshake: a stage moves when empty or when its successor takes
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // clamp model output to 1..32766
    always_comb
    begin
        if (prediction <= 16'sd0)
        begin
            o_clamp = O_MIN;
        end
        else if (prediction >= 16'sd32767)
        begin
            o_clamp = O_MAX;
        end
        else
        begin
            o_clamp = prediction[MAG_W-1:0];
        end
    end

    // denominator product and difference
    assign o_comp    = 16'd32768 - {1'b0, o_clamp};
    assign prod_full = PROD_W'({1'b0, o_clamp}) * PROD_W'(o_comp);
    assign diff      = $signed({3'b000, o_clamp}) - $signed({{2{target[DATA_W-1]}}, target});

    // stage a
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_op_reg   <= op_t'(operation);
            a_tgt_reg  <= target;
            a_o_reg    <= o_clamp;
            a_prod_reg <= prod_full;
            a_diff_reg <= diff;
        end
    end

    // bce operands: den forced to 1 when zero, half den added before division
    assign den     = a_prod_reg[PROD_W-1:FRAC_BITS];
    assign den_f   = (den == '0) ? O_MIN : den;
    assign bce_num = $signed({a_diff_reg, 15'b0}) + $signed({19'b0, den_f[MAG_W-1:1]});
    assign bce_mag = bce_num[32] ? $unsigned(-bce_num) : $unsigned(bce_num);

    // ce operand magnitude; -32768 maps to 32768
    assign tgt_mag = a_tgt_reg[DATA_W-1] ? $unsigned(-a_tgt_reg) : $unsigned(a_tgt_reg);

    // operand select per loss kind
    always_comb
    begin
        b_item_next         = '0;
        b_item_next.divisor = O_MIN;
        dvd                 = '0;
        unique case (a_op_reg)
            OP_MSE:
            begin
                b_item_next.bypass = sat16(a_diff_reg);
            end
            OP_BCE:
            begin
                b_item_next.use_div = 1'b1;
                b_item_next.neg     = bce_num[32];
                b_item_next.divisor = den_f;
                dvd                 = bce_mag[DIVIDEND_W-1:0];
            end
            OP_CE:
            begin
                b_item_next.use_div = 1'b1;
                b_item_next.neg     = !a_tgt_reg[DATA_W-1] && (a_tgt_reg != 16'sd0);
                b_item_next.divisor = a_o_reg;
                dvd                 = {tgt_mag, 15'b0};
            end
            default:
            begin
                b_item_next.bypass = '0;
            end
        endcase
        b_item_next.ovf = dvd >= {1'b0, b_item_next.divisor, 15'b0};
        b_item_next.rem = dvd[2*MAG_W-1:MAG_W];
        b_item_next.low = dvd[MAG_W-1:0];
        b_item_next.quo = '0;
    end

    // stage b
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

>>> hw/rtl/qld_div_stage.sv
`timescale 1ns / 1ps
// qld_div_stage: one register stage of the restoring divider, DIV_STEPS quotient bits
// depends on qld_pkg

module qld_div_stage
    import qld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output div_item_t out_item
);

    logic          valid_reg;
    div_item_t     item_reg;
    div_item_t     item_next;
    logic [MAG_W:0] trial;

    assign in_ready = !valid_reg || out_ready;

    // shift in one dividend bit per step, subtract when the divisor fits
    always_comb
    begin
        item_next = in_item;
        trial     = '0;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            trial         = {item_next.rem, item_next.low[MAG_W-1]};
            item_next.low = {item_next.low[MAG_W-2:0], 1'b0};
            if (trial >= {1'b0, item_next.divisor})
            begin
                item_next.rem = MAG_W'(trial - {1'b0, item_next.divisor});
                item_next.quo = {item_next.quo[MAG_W-2:0], 1'b1};
            end
            else
            begin
                item_next.rem = trial[MAG_W-1:0];
                item_next.quo = {item_next.quo[MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> hw/rtl/qld_post.sv
`timescale 1ns / 1ps
// qld_post: sign, saturation and output register
// depends on qld_pkg

module qld_post
    import qld_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  div_item_t                in_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] derivative
);

    logic                     valid_reg;
    logic signed [DATA_W-1:0] der_reg;
    logic signed [DATA_W-1:0] der_next;
    logic [DATA_W-1:0]        q16;

    assign in_ready = !valid_reg || out_ready;
    assign q16      = {1'b0, in_item.quo};

    // pick bypass, saturated bound or signed quotient
    always_comb
    begin
        if (!in_item.use_div)
        begin
            der_next = in_item.bypass;
        end
        else if (in_item.ovf)
        begin
            der_next = in_item.neg ? DER_MIN : DER_MAX;
        end
        else if (in_item.neg)
        begin
            der_next = $signed(~q16 + 16'd1);
        end
        else
        begin
            der_next = $signed(q16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            der_reg <= der_next;
        end
    end

    assign out_valid  = valid_reg;
    assign derivative = der_reg;

endmodule

>>> hw/rtl/q15_loss_derivative.sv
`timescale 1ns / 1ps
// q15_loss_derivative: top level of the pipelined q15 loss derivative
// depends on qld_pkg, qld_prep, qld_div_stage, qld_post
//
// channel | handshake           | payload
// --------+---------------------+------------------------------------
// in      | in_valid, in_ready  | operation[1:0], target[15:0], prediction[15:0]
// out     | out_valid, out_ready| derivative[15:0]
//
// one beat enters per cycle while the output is not stalled; the stages are clamp and product,
// operand setup, five divider stages of three quotient bits each, output register.
// the restoring divider (15 quotient bits) sets the depth.
// every stage holds its beat while the next one is full, so stalls lose nothing.
// reset clears only the stage valid bits; no clearing pass.

module q15_loss_derivative
    import qld_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               operation,
    input  logic signed [DATA_W-1:0] target,
    input  logic signed [DATA_W-1:0] prediction,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] derivative
);

    logic [DIV_STAGES:0] stg_valid;
    logic [DIV_STAGES:0] stg_ready;
    div_item_t           stg_item [DIV_STAGES+1];

    // clamp, product and operand setup
    qld_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .target     (target),
        .prediction (prediction),
        .out_valid  (stg_valid[0]),
        .out_ready  (stg_ready[0]),
        .out_item   (stg_item[0])
    );

    // divider chain
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        qld_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_item   (stg_item[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_item  (stg_item[i+1])
        );
    end

    // sign, saturation and output register
    qld_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stg_valid[DIV_STAGES]),
        .in_ready   (stg_ready[DIV_STAGES]),
        .in_item    (stg_item[DIV_STAGES]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .derivative (derivative)
    );

`ifndef NO_ASSERTIONS
    // an empty output register means no stage can block the input
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register empty");

    // a draining output frees the whole chain
    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // a saturated quotient never reaches the output as a plain quotient
    a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[DIV_STAGES] && stg_ready[DIV_STAGES] && stg_item[DIV_STAGES].use_div
        && stg_item[DIV_STAGES].ovf
        |=> (derivative == DER_MAX) || (derivative == DER_MIN))
        else $error("overflowed quotient not saturated");
`endif

endmodule
